// ----- rtl/rfid_ascii_hex_frame_decoder_macros.svh -----
// Assertion macros shared by the tag frame decoder RTL.
`ifndef RFID_ASCII_HEX_FRAME_DECODER_MACROS_SVH
`define RFID_ASCII_HEX_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define RFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define RFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define RFD_ASSERT(lbl, clk, rst_n, prop)
`define RFD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/rfd_pkg.sv -----
// Package: constants, result type and character decode for the tag frame decoder.
`default_nettype none

package rfd_pkg;

  localparam int ByteW         = 8;
  localparam int TagW          = 40;
  localparam int FrameBytesDef = 6;

  localparam logic [ByteW-1:0] StartByte = 8'h02;
  localparam logic [ByteW-1:0] EndByte   = 8'h03;
  localparam logic [ByteW-1:0] AsciiZero = 8'd48;
  localparam logic [ByteW-1:0] DecMax    = 8'd9;
  localparam logic [ByteW-1:0] HexGap    = 8'd7;

  typedef struct packed {
    logic            tag_valid;
    logic [TagW-1:0] tag_id;
  } result_t;

  // Reduce an uppercase ASCII hex character to its value, modulo 256; lowercase
  // and non-hex input go through the same arithmetic.
  function automatic logic [ByteW-1:0] hex_digit(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = c - AsciiZero;
    if (d > DecMax) begin
      d = d - HexGap;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rfid_ascii_hex_frame_decoder.sv -----
// Top level of the ASCII hex tag frame decoder.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   rx      | in        | in_valid_i / in_ready_o | rx_byte_i [7:0]
//   tag     | out       | out_valid_o / out_ready_i | tag_valid_o, tag_id_o [39:0]
//
// One byte is accepted per cycle unless a waiting result stalls the input; its result item appears in the next cycle.
// The frame state and the payload bytes update at the accepting edge, and the
// result lands in a single output register.
// A waiting result blocks the input only while out_ready_i is low; taking it
// frees the register in the same cycle, so a new byte can enter.
// Reset (rst_ni low, asynchronous) puts the tracker in idle and empties the
// output register.
`default_nettype none

module rfid_ascii_hex_frame_decoder #(
  parameter int FRAME_BYTES = rfd_pkg::FrameBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [rfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           tag_valid_o,
  output logic [rfd_pkg::TagW-1:0]       tag_id_o
);

  // Every accepted byte yields exactly one result item.
  logic             accept;
  rfd_pkg::result_t frame_res;
  rfd_pkg::result_t out_res;

  assign accept = in_valid_i && in_ready_o;

  // Decode, frame tracking and checksum compare live in the tracker. Its
  // result is combinational from the current state and the incoming byte.
  rfd_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .res_o    (frame_res)
  );

  // The output register parts the two handshakes.
  rfd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .res_i      (frame_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (out_res)
  );

  assign tag_valid_o = out_res.tag_valid;
  assign tag_id_o    = out_res.tag_id;

endmodule

`default_nettype wire

// ----- rtl/rfd_frame.sv -----
// Frame tracker: decodes one byte per cycle while accept_i is high, keeps the payload and checks the XOR.
`default_nettype none
`include "rfid_ascii_hex_frame_decoder_macros.svh"

module rfd_frame #(
  parameter int FRAME_BYTES = rfd_pkg::FrameBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [rfd_pkg::ByteW-1:0] rx_byte_i,
  output rfd_pkg::result_t               res_o
);

  localparam int ByteW = rfd_pkg::ByteW;
  localparam int TagW  = rfd_pkg::TagW;
  localparam int CntW  = $clog2(FRAME_BYTES + 1);
  localparam int IdxW  = $clog2(FRAME_BYTES);
  localparam int PayW  = (FRAME_BYTES - 1) * ByteW;
  localparam logic [CntW-1:0] CntLast = CntW'(FRAME_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_WAIT = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] high_q;
  logic [ByteW-1:0] fb_q [FRAME_BYTES];

  logic [ByteW-1:0] digit;
  logic [ByteW-1:0] pair_byte;
  logic [CntW-1:0]  cnt_inc;
  logic             is_start;
  logic             is_end;
  logic [PayW-1:0]  payload;

  assign digit     = rfd_pkg::hex_digit(rx_byte_i);
  assign pair_byte = {high_q[3:0], 4'b0000} | digit;
  assign cnt_inc   = cnt_q + 1'b1;
  assign is_start  = (rx_byte_i == rfd_pkg::StartByte);
  assign is_end    = (rx_byte_i == rfd_pkg::EndByte);

  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      payload[(FRAME_BYTES - 2 - i) * ByteW +: ByteW] = fb_q[i];
    end
  end

  always_comb begin
    phase_d         = phase_q;
    cnt_d           = cnt_q;
    xor_d           = xor_q;
    res_o.tag_valid = 1'b0;
    res_o.tag_id    = '0;
    if (is_start) begin
      phase_d = PH_HIGH;
      cnt_d   = '0;
      xor_d   = '0;
    end else begin
      case (phase_q)
        PH_HIGH: phase_d = PH_LOW;
        PH_LOW: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntLast) begin
            phase_d = PH_WAIT;
          end else begin
            xor_d   = xor_q ^ pair_byte;
            phase_d = PH_HIGH;
          end
        end
        PH_WAIT: begin
          if (is_end) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            if (xor_q == fb_q[FRAME_BYTES-1]) begin
              res_o.tag_valid = 1'b1;
              res_o.tag_id    = TagW'(payload);
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  // Payload storage needs no reset: every entry is written before it is read.
  always_ff @(posedge clk_i) begin
    if (accept_i && !is_start) begin
      if (phase_q == PH_HIGH) begin
        high_q <= digit;
      end
      if (phase_q == PH_LOW) begin
        fb_q[cnt_q[IdxW-1:0]] <= pair_byte;
      end
    end
  end

  `RFD_ASSERT(a_wait_full, clk_i, rst_ni, (phase_q == PH_WAIT) |-> (cnt_q == CntLast))
  `RFD_ASSERT(a_pair_in_range, clk_i, rst_ni,
              (phase_q == PH_HIGH || phase_q == PH_LOW) |-> (cnt_q < CntLast))
  `RFD_ASSERT(a_hit_only_at_end, clk_i, rst_ni,
              res_o.tag_valid |-> (is_end && phase_q == PH_WAIT))

endmodule

`default_nettype wire

// ----- rtl/rfd_out_reg.sv -----
// Result register: holds one result item until the consumer takes it.
`default_nettype none
`include "rfid_ascii_hex_frame_decoder_macros.svh"

module rfd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rfd_pkg::result_t res_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rfd_pkg::result_t      res_o
);

  logic             valid_q;
  rfd_pkg::result_t res_q;
  logic             load;

  // The register frees up in the same cycle its content is taken.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  `RFD_ASSERT(a_load_shows, clk_i, rst_ni, load |=> valid_q)
  `RFD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, valid_q && !out_ready_i && in_ready_o)
  `RFD_ASSERT(a_miss_zero_tag, clk_i, rst_ni,
              (valid_q && !res_q.tag_valid) |-> (res_q.tag_id == '0))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the ASCII hex tag frame decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PayloadBytes = rfd_pkg::FrameBytesDef;
  localparam int ByteW        = rfd_pkg::ByteW;
  localparam int TagW         = rfd_pkg::TagW;
  localparam int StallLimit   = 2000;
  localparam int GapCap       = 40;
  localparam int RandomItems  = 1400;

  // Decoder phase, tracked alongside the block.
  typedef enum logic [1:0] {
    SEEK_START,
    HIGH_CHAR,
    LOW_CHAR,
    AWAIT_END
  } frame_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready_o;
  logic [ByteW-1:0]    rx_byte;
  logic                out_valid_o;
  logic                out_ready;
  logic                tag_valid_o;
  logic [TagW-1:0]     tag_id_o;

  rfid_ascii_hex_frame_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .tag_valid_o (tag_valid_o),
    .tag_id_o    (tag_id_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the frame tracker.
  frame_phase_e     trk_phase;
  int unsigned      trk_count;
  logic [ByteW-1:0] trk_high;
  logic [ByteW-1:0] trk_xor;
  logic [ByteW-1:0] trk_payload [PayloadBytes];

  // Results still owed by the block, oldest first.
  rfd_pkg::result_t tag_expected [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // One ASCII character reduced to its digit value, wrapping in 8 bits, so
  // that non-hex characters still produce some value.
  function automatic logic [ByteW-1:0] char_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    v = c - 8'd48;
    if (v > 8'd9) begin
      v = v - 8'd7;
    end
    return v;
  endfunction

  // Advances the shadow tracker by one accepted item and returns the result
  // that the block must produce for it.
  function automatic rfd_pkg::result_t decode_byte(input logic [ByteW-1:0] c);
    rfd_pkg::result_t res;
    logic [ByteW-1:0] b;
    res = '0;
    if (c == rfd_pkg::StartByte) begin
      // A start byte restarts the frame no matter where the tracker is.
      trk_count = 0;
      trk_xor   = '0;
      trk_high  = '0;
      trk_phase = HIGH_CHAR;
    end else begin
      case (trk_phase)
        HIGH_CHAR: begin
          trk_high  = char_value(c);
          trk_phase = LOW_CHAR;
        end
        LOW_CHAR: begin
          // The pair combines in 8 bits; a wide low digit overlaps the high one.
          b = (trk_high << 4) | char_value(c);
          trk_high = b;
          if (trk_count < PayloadBytes) begin
            trk_payload[trk_count] = b;
          end
          trk_count++;
          if (trk_count >= PayloadBytes) begin
            trk_phase = AWAIT_END;
          end else begin
            trk_xor   = trk_xor ^ b;
            trk_phase = HIGH_CHAR;
          end
        end
        AWAIT_END: begin
          // Anything other than the end byte is ignored here.
          if (c == rfd_pkg::EndByte) begin
            trk_phase = SEEK_START;
            trk_count = 0;
            if (trk_xor == trk_payload[PayloadBytes-1]) begin
              res.tag_valid = 1'b1;
              for (int i = 0; i < PayloadBytes - 1; i++) begin
                res.tag_id = (res.tag_id << 8) | TagW'(trk_payload[i]);
              end
            end
          end
        end
        default: begin
          trk_phase = SEEK_START;
        end
      endcase
    end
    return res;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned pct);
    int unsigned n;
    n = 0;
    while (n < GapCap && $urandom_range(99) < pct) begin
      n++;
    end
    return n;
  endfunction

  // Offers one item at a falling edge, after an optional idle gap, and holds
  // it until the block takes it at a rising edge.
  task automatic send_byte(input logic [ByteW-1:0] c);
    int unsigned gap;
    gap = draw_gap(send_idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Stops offering items and waits until every owed result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tag_expected.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib,
                                                 input bit lower);
    if (nib < 4'd10) begin
      return 8'd48 + nib;
    end
    return (lower ? 8'd87 : 8'd55) + nib;
  endfunction

  // Sends a start byte and the twelve characters of the given bytes.
  task automatic send_frame_chars(input logic [ByteW-1:0] frame [PayloadBytes],
                                  input bit lower);
    send_byte(rfd_pkg::StartByte);
    for (int i = 0; i < PayloadBytes; i++) begin
      send_byte(hex_char(frame[i][7:4], lower));
      send_byte(hex_char(frame[i][3:0], lower));
    end
  endtask

  task automatic note_mismatch(input string what, input rfd_pkg::result_t want,
                               input rfd_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected valid=%0b id=%010h, got valid=%0b id=%010h",
               $realtime, what, want.tag_valid, want.tag_id, got.tag_valid,
               got.tag_id);
    end
  endtask

  // Scoreboard: results are matched before the item accepted at the same edge
  // is predicted, since that item's result must first pass the output register.
  rfd_pkg::result_t got_res;
  rfd_pkg::result_t want_res;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got_res.tag_valid = tag_valid_o;
        got_res.tag_id    = tag_id_o;
        if (tag_expected.size() == 0) begin
          note_mismatch("unexpected result", '0, got_res);
        end else begin
          want_res = tag_expected.pop_front();
          if (got_res.tag_valid !== want_res.tag_valid) begin
            note_mismatch("tag_valid mismatch", want_res, got_res);
          end else if (got_res.tag_id !== want_res.tag_id) begin
            note_mismatch("tag_id mismatch", want_res, got_res);
          end
        end
      end
      if (in_valid && in_ready_o) begin
        tag_expected.push_back(decode_byte(rx_byte));
      end
    end
  end

  // Receiver: stalls at random, decided at each falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Bytes outside a frame, including an end byte with no frame open.
  task automatic test_idle_bytes();
    send_byte(8'hFF);
    send_byte(rfd_pkg::EndByte);
    send_byte(8'h00);
  endtask

  // A frame that restarts once, then completes with every payload bit set;
  // a stray character while waiting for the end byte is ignored.
  task automatic test_restart_and_full_tag();
    logic [ByteW-1:0] frame [PayloadBytes];
    send_byte(rfd_pkg::StartByte);
    send_byte("F");
    for (int i = 0; i < PayloadBytes; i++) begin
      frame[i] = 8'hFF;
    end
    send_frame_chars(frame, 1'b0);
    send_byte("A");
    send_byte(rfd_pkg::EndByte);
  endtask

  // An end byte inside the payload is taken as a character, and the frame
  // then ends with a checksum that does not match.
  task automatic test_early_end_bad_checksum();
    send_byte(rfd_pkg::StartByte);
    send_byte(rfd_pkg::EndByte);
    repeat (9) send_byte("0");
    send_byte("0");
    send_byte("1");
    send_byte(rfd_pkg::EndByte);
  endtask

  // Mostly well-formed frames with random content, some with a broken
  // checksum, corrupted characters or a missing end byte, plus bursts of
  // random bytes. Runs until the item budget of this phase is used.
  task automatic test_random_traffic(input int unsigned budget);
    logic [ByteW-1:0] frame [PayloadBytes];
    logic [ByteW-1:0] chk;
    logic [ByteW-1:0] c;
    bit               lower;
    int unsigned      stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom_range(255)));
      end else begin
        chk = '0;
        for (int i = 0; i < PayloadBytes - 1; i++) begin
          frame[i] = ByteW'($urandom_range(255));
          chk      = chk ^ frame[i];
        end
        frame[PayloadBytes-1] = ($urandom_range(99) < 20) ?
                                ByteW'($urandom_range(255)) : chk;
        lower = ($urandom_range(99) < 10);
        send_byte(rfd_pkg::StartByte);
        for (int i = 0; i < 2 * PayloadBytes; i++) begin
          c = hex_char(i[0] ? frame[i/2][3:0] : frame[i/2][7:4], lower);
          if ($urandom_range(99) < 3) begin
            c = ByteW'($urandom_range(255));
          end
          send_byte(c);
        end
        repeat ($urandom_range(0, 2)) begin
          c = ByteW'($urandom_range(255));
          if (c == rfd_pkg::EndByte) begin
            c = 8'h7E;
          end
          send_byte(c);
        end
        if ($urandom_range(99) < 90) begin
          send_byte(rfd_pkg::EndByte);
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    rx_byte        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    bytes_sent     = 0;
    idle_cycles    = 0;
    trk_phase      = SEEK_START;
    trk_count      = 0;
    trk_high       = '0;
    trk_xor        = '0;
    for (int i = 0; i < PayloadBytes; i++) begin
      trk_payload[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_bytes();
    test_restart_and_full_tag();
    test_early_end_bad_checksum();
    drain_results();

    // Idling phases: none, sender idle, receiver stalling, both.
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_traffic(RandomItems / 4);
    drain_results();
    send_idle_pct = 79; recv_stall_pct = 0;
    test_random_traffic(RandomItems / 4);
    drain_results();
    send_idle_pct = 0;  recv_stall_pct = 79;
    test_random_traffic(RandomItems / 4);
    drain_results();
    send_idle_pct = 38; recv_stall_pct = 38;
    test_random_traffic(RandomItems / 4);
    drain_results();

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && tag_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
